[sv/tfr_pkg.sv]
// shared types and codes for the four-register cpu step core
`default_nettype none
package tfr_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] address;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic [8:0] pc;
    logic [7:0] reg0;
    logic [7:0] reg1;
    logic [7:0] reg2;
    logic [7:0] reg3;
    logic       zero;
    logic       carry;
    logic       running;
  } res_t;

  typedef struct packed {
    logic start;
    logic exec;
    logic load_done;
    logic imm_ok;
  } exec_ctl_t;

  typedef struct packed {
    logic       fetch_ok;
    logic       need_load;
    logic       store_en;
    logic [7:0] mem_addr;
    logic [7:0] store_data;
  } exec_status_t;

  localparam logic [1:0] FN_PROG = 2'd0;
  localparam logic [1:0] FN_DATA = 2'd1;
  localparam logic [1:0] FN_EXEC = 2'd2;

  localparam logic [3:0] OP_JUMP    = 4'd0;
  localparam logic [3:0] OP_HALT    = 4'd1;
  localparam logic [3:0] OP_MOV_IMM = 4'd2;
  localparam logic [3:0] OP_NOP     = 4'd3;
  localparam logic [3:0] OP_MOV_REG = 4'd4;
  localparam logic [3:0] OP_ADD     = 4'd5;
  localparam logic [3:0] OP_JC      = 4'd6;
  localparam logic [3:0] OP_JZ      = 4'd7;
  localparam logic [3:0] OP_LOAD    = 4'd8;
  localparam logic [3:0] OP_STORE   = 4'd9;

endpackage
`default_nettype wire

[sv/tfr_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module tfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/tfr_exec.sv]
// architectural registers, instruction decode and alu
`default_nettype none
module tfr_exec (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tfr_pkg::exec_ctl_t    ctl,
  input  wire logic [7:0]            ibyte,
  input  wire logic [7:0]            imm,
  input  wire logic [7:0]            load_data,
  input  wire logic [8:0]            prog_len,
  output tfr_pkg::res_t              snap,
  output tfr_pkg::exec_status_t      status
);
  import tfr_pkg::*;

  logic [7:0] rf [4];
  logic [8:0] pc;
  logic       zero;
  logic       carry;
  logic       running;

  logic [3:0] op;
  logic [3:0] op_eff;
  logic [1:0] dst;
  logic [1:0] src;
  logic       need_imm;
  logic       has_imm;
  logic       fetch_ok;
  logic [8:0] pc_inc1;
  logic [8:0] pc_inc2;
  logic [8:0] sum;

  assign op      = ibyte[7:4];
  assign dst     = ibyte[3:2];
  assign src     = ibyte[1:0];
  assign pc_inc1 = pc + 9'd1;
  assign pc_inc2 = pc + 9'd2;
  assign has_imm = (pc_inc1 < prog_len);
  assign fetch_ok = running && (pc < prog_len);
  assign sum     = {1'b0, rf[dst]} + {1'b0, rf[src]};

  always_comb begin
    unique case (op) inside
      OP_JUMP, OP_MOV_IMM, OP_JC, OP_JZ, OP_LOAD, OP_STORE: need_imm = 1'b1;
      default: need_imm = 1'b0;
    endcase
  end

  always_comb begin
    op_eff = op;
    if ((op > OP_STORE) || (need_imm && !has_imm)) begin
      op_eff = OP_HALT;
    end
  end

  always_comb begin
    status.fetch_ok   = fetch_ok;
    status.need_load  = (op_eff == OP_LOAD) && ctl.imm_ok;
    status.store_en   = ctl.exec && (op_eff == OP_STORE) && ctl.imm_ok;
    status.mem_addr   = imm;
    status.store_data = rf[src];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rf[i] <= 8'd0;
      end
      pc      <= 9'd0;
      zero    <= 1'b0;
      carry   <= 1'b0;
      running <= 1'b1;
    end else begin
      if (ctl.start && running && !fetch_ok) begin
        running <= 1'b0;
      end
      if (ctl.exec) begin
        unique case (op_eff)
          OP_JUMP: begin
            pc <= {1'b0, imm};
          end
          OP_HALT: begin
            running <= 1'b0;
          end
          OP_MOV_IMM: begin
            rf[dst] <= imm;
            pc      <= pc_inc2;
          end
          OP_NOP: begin
            pc <= pc_inc1;
          end
          OP_MOV_REG: begin
            rf[dst] <= rf[src];
            pc      <= pc_inc1;
          end
          OP_ADD: begin
            rf[dst] <= sum[7:0];
            zero    <= (sum[7:0] == 8'd0);
            carry   <= sum[8];
            pc      <= pc_inc1;
          end
          OP_JC: begin
            pc <= carry ? {1'b0, imm} : pc_inc2;
          end
          OP_JZ: begin
            pc <= zero ? {1'b0, imm} : pc_inc2;
          end
          OP_LOAD: begin
            if (!ctl.imm_ok) begin
              pc <= pc_inc2;
            end
          end
          OP_STORE: begin
            pc <= pc_inc2;
          end
          default: begin
            running <= 1'b0;
          end
        endcase
      end
      if (ctl.load_done) begin
        rf[dst] <= load_data;
        pc      <= pc_inc2;
      end
    end
  end

  always_comb begin
    snap.pc      = pc;
    snap.reg0    = rf[0];
    snap.reg1    = rf[1];
    snap.reg2    = rf[2];
    snap.reg3    = rf[3];
    snap.zero    = zero;
    snap.carry   = carry;
    snap.running = running;
  end

endmodule
`default_nettype wire

[sv/tiny_four_register_cpu_step_core.sv]
// top level of the four-register cpu step core
//
//   channel  direction  handshake              payload
//   cmd      in         cmd_valid / cmd_stall  tfr_pkg::cmd_t
//   res      out        res_valid / res_stall  tfr_pkg::res_t
//   cfg      in         cfg_write              cfg_data (program length)
//
// program and data writes pass through ST_IDLE then ST_DONE, an instruction ST_IDLE, ST_EXEC,
// ST_DONE (ST_IDLE, ST_DONE when it cannot fetch), a load adds ST_LOAD before ST_DONE; the
// registered program store read (two copies, opcode and immediate) and data read set these states
// after reset the data memory is cleared, one entry a cycle, with cmd_stall high
// until the last entry is written
// a result waits in the output register while the next transfer is taken
`default_nettype none
module tiny_four_register_cpu_step_core #(
  parameter int PROGRAM_DEPTH = 256,
  parameter int DATA_DEPTH    = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire tfr_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_stall,
  output tfr_pkg::res_t      res,
  input  wire logic          cfg_write,
  input  wire logic [8:0]    cfg_data
);
  import tfr_pkg::*;

  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam logic [8:0] PROG_DEPTH_W = 9'(PROGRAM_DEPTH);
  localparam logic [8:0] DATA_DEPTH_W = 9'(DATA_DEPTH);
  localparam logic [DAW-1:0] CLR_LAST = DAW'(DATA_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [DAW-1:0] clr_addr;
  logic [8:0]     prog_len;
  logic [8:0]     eff_len;
  logic           accept;
  logic           res_load;

  logic           prog_we;
  logic           prog_re;
  logic [7:0]     ibyte;
  logic [7:0]     imm;

  logic           data_we;
  logic [DAW-1:0] data_waddr;
  logic [7:0]     data_wdata;
  logic           data_re;
  logic [7:0]     load_data;

  exec_ctl_t      ctl;
  exec_status_t   status;
  res_t           snap;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign eff_len   = (prog_len > PROG_DEPTH_W) ? PROG_DEPTH_W : prog_len;
  assign res_load  = (state == ST_DONE) && (!res_valid || !res_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd.func == FN_EXEC && status.fetch_ok) ? ST_EXEC : ST_DONE;
        end
      end
      ST_EXEC: begin
        state_next = status.need_load ? ST_LOAD : ST_DONE;
      end
      ST_LOAD: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      prog_len <= 9'd0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_write) begin
        prog_len <= cfg_data;
      end
    end
  end

  // program store, one copy per read address
  assign prog_we = accept && (cmd.func == FN_PROG) && ({1'b0, cmd.address} < PROG_DEPTH_W);
  assign prog_re = accept && (cmd.func == FN_EXEC) && status.fetch_ok;

  tfr_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog_op (
    .clk     (clk),
    .wr_en   (prog_we),
    .wr_addr (PAW'(cmd.address)),
    .wr_data (cmd.value),
    .rd_en   (prog_re),
    .rd_addr (PAW'(snap.pc)),
    .rd_data (ibyte)
  );

  tfr_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog_imm (
    .clk     (clk),
    .wr_en   (prog_we),
    .wr_addr (PAW'(cmd.address)),
    .wr_data (cmd.value),
    .rd_en   (prog_re),
    .rd_addr (PAW'(snap.pc + 9'd1)),
    .rd_data (imm)
  );

  // data memory: clear sweep, direct writes and stores share the write port
  always_comb begin
    data_we    = 1'b0;
    data_waddr = clr_addr;
    data_wdata = 8'd0;
    if (state == ST_CLEAR) begin
      data_we = 1'b1;
    end else if (accept && cmd.func == FN_DATA) begin
      data_we    = ({1'b0, cmd.address} < DATA_DEPTH_W);
      data_waddr = DAW'(cmd.address);
      data_wdata = cmd.value;
    end else if (status.store_en) begin
      data_we    = 1'b1;
      data_waddr = DAW'(status.mem_addr);
      data_wdata = status.store_data;
    end
  end

  assign data_re = (state == ST_EXEC) && status.need_load;

  tfr_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (data_waddr),
    .wr_data (data_wdata),
    .rd_en   (data_re),
    .rd_addr (DAW'(status.mem_addr)),
    .rd_data (load_data)
  );

  always_comb begin
    ctl.start     = accept && (cmd.func == FN_EXEC);
    ctl.exec      = (state == ST_EXEC);
    ctl.load_done = (state == ST_LOAD);
    ctl.imm_ok    = ({1'b0, imm} < DATA_DEPTH_W);
  end

  tfr_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .ibyte     (ibyte),
    .imm       (imm),
    .load_data (load_data),
    .prog_len  (eff_len),
    .snap      (snap),
    .status    (status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= snap;
    end
  end

endmodule
`default_nettype wire
